[hdl/cpf_pkg.sv]
package cpf_pkg;

    localparam int ID_W    = 29;
    localparam int NUM_W   = 8;
    localparam int KIND_W  = 3;
    localparam int HITS_W  = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_FILTER = 2'd3;

    localparam logic [KIND_W-1:0] KIND_UNSET       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BLACK_EXACT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BLACK_MASK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WHITE_EXACT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WHITE_MASK  = 3'd4;

    localparam logic [1:0] OUT_DONE      = 2'd0;
    localparam logic [1:0] OUT_FULL      = 2'd1;
    localparam logic [1:0] OUT_NOT_FOUND = 2'd2;

    localparam logic [NUM_W-1:0] NUM_NONE = 8'd0;
    localparam logic [NUM_W-1:0] NUM_MAX  = 8'd255;

    typedef struct packed {
        logic [NUM_W-1:0]  number;
        logic              enabled;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   value;
        logic [ID_W-1:0]   mask;
        logic [HITS_W-1:0] hits;
    } entry_t;

    typedef struct packed {
        logic id_match;
        logic num_equal;
        logic num_greater;
    } cmp_res_t;

endpackage

[hdl/cpf_table.sv]
module cpf_table #(
    parameter int TABLE_SLOTS = 16,
    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
    input  logic             clk,
    input  logic [IDX_W-1:0] rd_addr,
    output cpf_pkg::entry_t  rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  cpf_pkg::entry_t  wr_data
);
    import cpf_pkg::*;

    entry_t mem [TABLE_SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/cpf_cmp.sv]
module cpf_cmp (
    input  cpf_pkg::entry_t                 ent,
    input  logic [cpf_pkg::ID_W-1:0]        ident,
    input  logic [cpf_pkg::NUM_W-1:0]       key_num,
    input  logic [cpf_pkg::NUM_W-1:0]       best_num,
    output cpf_pkg::cmp_res_t               res
);
    import cpf_pkg::*;

    always_comb
    begin
        res.num_equal   = (ent.number == key_num);
        res.num_greater = (ent.number > best_num);
        unique case (ent.kind)
            KIND_BLACK_EXACT, KIND_WHITE_EXACT:
                res.id_match = (ent.value == ident);
            KIND_BLACK_MASK, KIND_WHITE_MASK:
                res.id_match = ((ent.value & ent.mask) == (ident & ent.mask));
            default:
                res.id_match = 1'b0;
        endcase
    end

endmodule

[hdl/cpf_seq.sv]
module cpf_seq #(
    parameter int TABLE_SLOTS = 16,
    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        command,
    input  logic [cpf_pkg::ID_W-1:0]          frame_ident,
    input  logic [cpf_pkg::NUM_W-1:0]         filter_number,
    input  logic [cpf_pkg::KIND_W-1:0]        filter_kind,
    input  logic                              enable_flag,
    input  logic [cpf_pkg::ID_W-1:0]          match_value,
    input  logic [cpf_pkg::ID_W-1:0]          match_mask,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              accepted,
    output logic                              matched,
    output logic [cpf_pkg::NUM_W-1:0]         entry_number,
    output logic [cpf_pkg::HITS_W-1:0]        hit_total,
    output logic [1:0]                        outcome,
    output logic [IDX_W-1:0]                  rd_addr,
    input  cpf_pkg::entry_t                   rd_data,
    output logic                              wr_en,
    output logic [IDX_W-1:0]                  wr_addr,
    output cpf_pkg::entry_t                   wr_data
);
    import cpf_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_ACT   = 5'b01000,
        S_HOLD  = 5'b10000
    } state_t;

    // control
    state_t                 state_reg, state_next;
    logic [TABLE_SLOTS-1:0] used_reg, used_next;
    logic [NUM_W-1:0]       newest_reg, newest_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   eval_vld_reg, eval_vld_next;

    // request capture
    logic [1:0]             cmd_reg, cmd_next;
    logic [ID_W-1:0]        ident_reg, ident_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic                   en_reg, en_next;
    logic [ID_W-1:0]        val_reg, val_next;
    logic [ID_W-1:0]        mask_reg, mask_next;

    // scan bookkeeping
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       eval_idx_reg, eval_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    entry_t                 hit_ent_reg, hit_ent_next;
    logic [NUM_W-1:0]       best_reg, best_next;

    // result and output stage
    logic                   res_accepted_reg, res_accepted_next;
    logic                   res_matched_reg, res_matched_next;
    logic [NUM_W-1:0]       res_entry_reg, res_entry_next;
    logic [HITS_W-1:0]      res_hits_reg, res_hits_next;
    logic [1:0]             res_outcome_reg, res_outcome_next;
    logic                   accepted_reg, accepted_next;
    logic                   matched_reg, matched_next;
    logic [NUM_W-1:0]       entry_number_reg, entry_number_next;
    logic [HITS_W-1:0]      hit_total_reg, hit_total_next;
    logic [1:0]             outcome_reg, outcome_next;

    cmp_res_t               cmp;
    logic                   slot_live;
    logic [NUM_W-1:0]       new_num;
    logic [HITS_W-1:0]      hits_inc;

    cpf_cmp u_cmp (
        .ent      (rd_data),
        .ident    (ident_reg),
        .key_num  (num_reg),
        .best_num (best_reg),
        .res      (cmp)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign rd_addr  = idx_reg;
    assign slot_live = used_reg[eval_idx_reg];
    assign new_num  = newest_reg + 8'd1;
    assign hits_inc = hit_ent_reg.hits + 32'd1;

    always_comb
    begin
        state_next        = state_reg;
        used_next         = used_reg;
        newest_next       = newest_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        eval_vld_next     = (state_reg == S_SCAN);
        eval_idx_next     = idx_reg;
        cmd_next          = cmd_reg;
        ident_next        = ident_reg;
        num_next          = num_reg;
        kind_next         = kind_reg;
        en_next           = en_reg;
        val_next          = val_reg;
        mask_next         = mask_reg;
        idx_next          = idx_reg;
        free_found_next   = free_found_reg;
        free_idx_next     = free_idx_reg;
        hit_found_next    = hit_found_reg;
        hit_idx_next      = hit_idx_reg;
        hit_ent_next      = hit_ent_reg;
        best_next         = best_reg;
        res_accepted_next = res_accepted_reg;
        res_matched_next  = res_matched_reg;
        res_entry_next    = res_entry_reg;
        res_hits_next     = res_hits_reg;
        res_outcome_next  = res_outcome_reg;
        accepted_next     = accepted_reg;
        matched_next      = matched_reg;
        entry_number_next = entry_number_reg;
        hit_total_next    = hit_total_reg;
        outcome_next      = outcome_reg;
        wr_en             = 1'b0;
        wr_addr           = hit_idx_reg;
        wr_data           = hit_ent_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = command;
                    ident_next      = frame_ident;
                    num_next        = filter_number;
                    kind_next       = filter_kind;
                    en_next         = enable_flag;
                    val_next        = match_value;
                    mask_next       = match_mask;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    hit_found_next  = 1'b0;
                    best_next       = NUM_NONE;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_ACT;
            end
            S_ACT:
            begin
                res_accepted_next = 1'b0;
                res_matched_next  = 1'b0;
                res_entry_next    = NUM_NONE;
                res_hits_next     = '0;
                res_outcome_next  = OUT_DONE;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (free_found_reg && newest_reg != NUM_MAX)
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = free_idx_reg;
                            wr_data.number  = new_num;
                            wr_data.enabled = 1'b1;
                            wr_data.kind    = kind_reg;
                            wr_data.value   = val_reg;
                            wr_data.mask    = mask_reg;
                            wr_data.hits    = '0;
                            used_next[free_idx_reg] = 1'b1;
                            newest_next     = new_num;
                            res_entry_next  = new_num;
                        end
                        else
                        begin
                            res_outcome_next = OUT_FULL;
                        end
                    end
                    CMD_UPDATE:
                    begin
                        if (hit_found_reg)
                        begin
                            wr_en           = 1'b1;
                            wr_data.enabled = en_reg;
                            wr_data.value   = val_reg;
                            wr_data.kind    = kind_reg;
                            wr_data.hits    = '0;
                        end
                        else
                        begin
                            res_outcome_next = OUT_NOT_FOUND;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_found_reg)
                        begin
                            used_next[hit_idx_reg] = 1'b0;
                            newest_next = best_reg;
                        end
                        else
                        begin
                            res_outcome_next = OUT_NOT_FOUND;
                        end
                    end
                    CMD_FILTER:
                    begin
                        if (hit_found_reg)
                        begin
                            wr_en             = 1'b1;
                            wr_data.hits      = hits_inc;
                            res_matched_next  = 1'b1;
                            res_entry_next    = hit_ent_reg.number;
                            res_hits_next     = hits_inc;
                            res_accepted_next = (hit_ent_reg.kind == KIND_WHITE_EXACT)
                                             || (hit_ent_reg.kind == KIND_WHITE_MASK);
                        end
                    end
                    default:
                    begin
                        res_outcome_next = OUT_DONE;
                    end
                endcase
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    accepted_next     = res_accepted_reg;
                    matched_next      = res_matched_reg;
                    entry_number_next = res_entry_reg;
                    hit_total_next    = res_hits_reg;
                    outcome_next      = res_outcome_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one slot per cycle through the shared compare unit
        if (eval_vld_reg)
        begin
            unique case (cmd_reg)
                CMD_INSERT:
                begin
                    if (!slot_live && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = eval_idx_reg;
                    end
                end
                CMD_UPDATE, CMD_REMOVE:
                begin
                    if (slot_live && num_reg != NUM_NONE && cmp.num_equal)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = eval_idx_reg;
                        hit_ent_next   = rd_data;
                    end
                    // highest number that survives a remove
                    if (slot_live && !cmp.num_equal && cmp.num_greater)
                    begin
                        best_next = rd_data.number;
                    end
                end
                CMD_FILTER:
                begin
                    if (slot_live && rd_data.enabled && cmp.id_match && cmp.num_greater)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = eval_idx_reg;
                        hit_ent_next   = rd_data;
                        best_next      = rd_data.number;
                    end
                end
                default:
                begin
                    hit_found_next = hit_found_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            newest_reg    <= NUM_NONE;
            out_valid_reg <= 1'b0;
            eval_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            newest_reg    <= newest_next;
            out_valid_reg <= out_valid_next;
            eval_vld_reg  <= eval_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        ident_reg        <= ident_next;
        num_reg          <= num_next;
        kind_reg         <= kind_next;
        en_reg           <= en_next;
        val_reg          <= val_next;
        mask_reg         <= mask_next;
        idx_reg          <= idx_next;
        eval_idx_reg     <= eval_idx_next;
        free_found_reg   <= free_found_next;
        free_idx_reg     <= free_idx_next;
        hit_found_reg    <= hit_found_next;
        hit_idx_reg      <= hit_idx_next;
        hit_ent_reg      <= hit_ent_next;
        best_reg         <= best_next;
        res_accepted_reg <= res_accepted_next;
        res_matched_reg  <= res_matched_next;
        res_entry_reg    <= res_entry_next;
        res_hits_reg     <= res_hits_next;
        res_outcome_reg  <= res_outcome_next;
        accepted_reg     <= accepted_next;
        matched_reg      <= matched_next;
        entry_number_reg <= entry_number_next;
        hit_total_reg    <= hit_total_next;
        outcome_reg      <= outcome_next;
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign matched      = matched_reg;
    assign entry_number = entry_number_reg;
    assign hit_total    = hit_total_reg;
    assign outcome      = outcome_reg;

endmodule

[hdl/can_id_prefilter_table_top.sv]
// CAN identifier prefilter table. Each request is one command: insert a filter
// (numbered newest + 1), update or remove an entry by number, or check a frame
// identifier, where the newest active matching entry decides pass or drop and
// its hit counter is bumped. Every command walks all TABLE_SLOTS entries once
// through a single compare unit, reading the entry memory a slot per cycle with
// a registered read. After the scan, a drain state lets the last read land,
// an act state acts on the scan and a hold state loads the output register.
// in_ready stays low meanwhile. A finished result waits in the output
// register; the next request can be taken while it waits, but its own
// result is held back until the previous one is taken.
module can_id_prefilter_table_top #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  command,
    input  logic [cpf_pkg::ID_W-1:0]    frame_ident,
    input  logic [cpf_pkg::NUM_W-1:0]   filter_number,
    input  logic [cpf_pkg::KIND_W-1:0]  filter_kind,
    input  logic                        enable_flag,
    input  logic [cpf_pkg::ID_W-1:0]    match_value,
    input  logic [cpf_pkg::ID_W-1:0]    match_mask,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        accepted,
    output logic                        matched,
    output logic [cpf_pkg::NUM_W-1:0]   entry_number,
    output logic [cpf_pkg::HITS_W-1:0]  hit_total,
    output logic [1:0]                  outcome
);
    import cpf_pkg::*;

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    entry_t           rd_data;
    entry_t           wr_data;

    cpf_seq #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .frame_ident   (frame_ident),
        .filter_number (filter_number),
        .filter_kind   (filter_kind),
        .enable_flag   (enable_flag),
        .match_value   (match_value),
        .match_mask    (match_mask),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .matched       (matched),
        .entry_number  (entry_number),
        .hit_total     (hit_total),
        .outcome       (outcome),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    cpf_table #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

[hdl/cpf_checker.sv]
module cpf_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        accepted,
    input  logic                        matched,
    input  logic [cpf_pkg::NUM_W-1:0]   entry_number,
    input  logic [cpf_pkg::HITS_W-1:0]  hit_total,
    input  logic [1:0]                  outcome
);
    import cpf_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(matched)
            && $stable(entry_number) && $stable(hit_total) && $stable(outcome))
        else $error("stalled result changed");

    // one request at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_no_match_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !matched |-> !accepted && hit_total == '0)
        else $error("verdict or count without a match");

    a_match_has_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && matched |-> entry_number != NUM_NONE && outcome == OUT_DONE)
        else $error("match without entry number");

    a_fail_no_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome != OUT_DONE |-> entry_number == NUM_NONE && !matched)
        else $error("failed command reports an entry");

endmodule

bind can_id_prefilter_table_top cpf_checker u_cpf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .matched      (matched),
    .entry_number (entry_number),
    .hit_total    (hit_total),
    .outcome      (outcome)
);

[test/can_id_filter_checker.sv]
`timescale 1ns / 1ps

module can_id_filter_checker #(
    parameter int SLOTS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [1:0]                  command,
    input  logic [cpf_pkg::ID_W-1:0]    frame_ident,
    input  logic [cpf_pkg::NUM_W-1:0]   filter_number,
    input  logic [cpf_pkg::KIND_W-1:0]  filter_kind,
    input  logic                        enable_flag,
    input  logic [cpf_pkg::ID_W-1:0]    match_value,
    input  logic [cpf_pkg::ID_W-1:0]    match_mask,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        accepted,
    input  logic                        matched,
    input  logic [cpf_pkg::NUM_W-1:0]   entry_number,
    input  logic [cpf_pkg::HITS_W-1:0]  hit_total,
    input  logic [1:0]                  outcome,
    output int                          fail_count,
    output int                          outstanding
);
    import cpf_pkg::*;

    typedef struct packed {
        logic              accepted;
        logic              matched;
        logic [NUM_W-1:0]  entry;
        logic [HITS_W-1:0] hits;
        logic [1:0]        outcome;
    } verdict_t;

    logic              tbl_used [SLOTS];
    logic [NUM_W-1:0]  tbl_num  [SLOTS];
    logic              tbl_on   [SLOTS];
    logic [KIND_W-1:0] tbl_kind [SLOTS];
    logic [ID_W-1:0]   tbl_val  [SLOTS];
    logic [ID_W-1:0]   tbl_msk  [SLOTS];
    logic [HITS_W-1:0] tbl_hits [SLOTS];
    logic [NUM_W-1:0]  newest;

    verdict_t pending_verdicts [$];
    int       errors  = 0;
    int       waiting = 0;

    assign fail_count  = errors;
    assign outstanding = waiting;

    function automatic int slot_of(logic [NUM_W-1:0] num);
        int found;
        found = -1;
        if (num != NUM_NONE)
            for (int i = 0; i < SLOTS; i++)
                if (tbl_used[i] && tbl_num[i] == num && found < 0)
                    found = i;
        return found;
    endfunction

    function automatic verdict_t run_command(
        logic [1:0]        cmd,
        logic [ID_W-1:0]   ident,
        logic [NUM_W-1:0]  num,
        logic [KIND_W-1:0] kind,
        logic              en,
        logic [ID_W-1:0]   val,
        logic [ID_W-1:0]   msk
    );
        verdict_t v;
        int       slot;
        logic     hit;
        v    = '0;
        slot = -1;
        case (cmd)
            CMD_INSERT:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (!tbl_used[i] && slot < 0)
                        slot = i;
                if (slot < 0 || newest == NUM_MAX)
                    v.outcome = OUT_FULL;
                else
                begin
                    newest         = newest + 1'b1;
                    tbl_used[slot] = 1'b1;
                    tbl_num[slot]  = newest;
                    tbl_on[slot]   = 1'b1;
                    tbl_kind[slot] = kind;
                    tbl_val[slot]  = val;
                    tbl_msk[slot]  = msk;
                    tbl_hits[slot] = '0;
                    v.entry        = newest;
                end
            end
            CMD_UPDATE:
            begin
                slot = slot_of(num);
                if (slot < 0)
                    v.outcome = OUT_NOT_FOUND;
                else
                begin
                    // mask stays as inserted
                    tbl_on[slot]   = en;
                    tbl_val[slot]  = val;
                    tbl_kind[slot] = kind;
                    tbl_hits[slot] = '0;
                end
            end
            CMD_REMOVE:
            begin
                slot = slot_of(num);
                if (slot < 0)
                    v.outcome = OUT_NOT_FOUND;
                else
                begin
                    tbl_used[slot] = 1'b0;
                    newest         = NUM_NONE;
                    for (int i = 0; i < SLOTS; i++)
                        if (tbl_used[i] && tbl_num[i] > newest)
                            newest = tbl_num[i];
                end
            end
            default:
            begin
                // newest active matching entry wins
                for (int i = 0; i < SLOTS; i++)
                begin
                    case (tbl_kind[i])
                        KIND_BLACK_EXACT, KIND_WHITE_EXACT:
                            hit = (tbl_val[i] == ident);
                        KIND_BLACK_MASK, KIND_WHITE_MASK:
                            hit = ((tbl_val[i] & tbl_msk[i]) == (ident & tbl_msk[i]));
                        default:
                            hit = 1'b0;
                    endcase
                    if (tbl_used[i] && tbl_on[i] && hit
                        && (slot < 0 || tbl_num[i] > tbl_num[slot]))
                        slot = i;
                end
                if (slot >= 0)
                begin
                    tbl_hits[slot] = tbl_hits[slot] + 1'b1;
                    v.matched      = 1'b1;
                    v.entry        = tbl_num[slot];
                    v.hits         = tbl_hits[slot];
                    v.accepted     = (tbl_kind[slot] == KIND_WHITE_EXACT
                                      || tbl_kind[slot] == KIND_WHITE_MASK);
                end
            end
        endcase
        return v;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                tbl_used[i] = 1'b0;
                tbl_num[i]  = NUM_NONE;
                tbl_on[i]   = 1'b0;
                tbl_kind[i] = KIND_UNSET;
                tbl_val[i]  = '0;
                tbl_msk[i]  = '0;
                tbl_hits[i] = '0;
            end
            newest = NUM_NONE;
            pending_verdicts.delete();
            waiting = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result with no request waiting");
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    check_field("accepted", want.accepted, accepted);
                    check_field("matched", want.matched, matched);
                    check_field("entry_number", want.entry, entry_number);
                    check_field("hit_total", want.hits, hit_total);
                    check_field("outcome", want.outcome, outcome);
                end
            end
            if (in_valid && in_ready)
                pending_verdicts.push_back(run_command(command, frame_ident, filter_number,
                                                       filter_kind, enable_flag, match_value,
                                                       match_mask));
            waiting = pending_verdicts.size();
        end
    end

endmodule

[test/tb_can_id_prefilter_table_top.sv]
`timescale 1ns / 1ps

module tb_can_id_prefilter_table_top;
    import cpf_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 375;
    localparam int LONG_STALL   = 400;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        command;
    logic [ID_W-1:0]   frame_ident;
    logic [NUM_W-1:0]  filter_number;
    logic [KIND_W-1:0] filter_kind;
    logic              enable_flag;
    logic [ID_W-1:0]   match_value;
    logic [ID_W-1:0]   match_mask;
    logic              out_valid;
    logic              out_ready;
    logic              accepted;
    logic              matched;
    logic [NUM_W-1:0]  entry_number;
    logic [HITS_W-1:0] hit_total;
    logic [1:0]        outcome;

    int fail_count;
    int outstanding;
    int tx_idle_pct      = 26;
    int rx_idle_pct      = 85;
    bit hold_off_request = 1'b0;

    logic [ID_W-1:0]  id_pool [8];
    logic [NUM_W-1:0] live_numbers [$];

    always #6 clk = ~clk;

    can_id_prefilter_table_top #(
        .TABLE_SLOTS (SLOTS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .frame_ident   (frame_ident),
        .filter_number (filter_number),
        .filter_kind   (filter_kind),
        .enable_flag   (enable_flag),
        .match_value   (match_value),
        .match_mask    (match_mask),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .matched       (matched),
        .entry_number  (entry_number),
        .hit_total     (hit_total),
        .outcome       (outcome)
    );

    can_id_filter_checker #(
        .SLOTS (SLOTS)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .frame_ident   (frame_ident),
        .filter_number (filter_number),
        .filter_kind   (filter_kind),
        .enable_flag   (enable_flag),
        .match_value   (match_value),
        .match_mask    (match_mask),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .matched       (matched),
        .entry_number  (entry_number),
        .hit_total     (hit_total),
        .outcome       (outcome),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    task automatic issue_request(
        logic [1:0]        cmd,
        logic [ID_W-1:0]   ident,
        logic [NUM_W-1:0]  num,
        logic [KIND_W-1:0] kind,
        logic              en,
        logic [ID_W-1:0]   val,
        logic [ID_W-1:0]   msk
    );
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        frame_ident   <= ident;
        filter_number <= num;
        filter_kind   <= kind;
        enable_flag   <= en;
        match_value   <= val;
        match_mask    <= msk;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
        // track live numbers so that update and remove can aim at real entries
        case (cmd)
            CMD_INSERT:
                if (live_numbers.size() < SLOTS
                    && (live_numbers.size() == 0 || live_numbers[$] != NUM_MAX))
                    live_numbers.push_back(live_numbers.size() == 0 ?
                                           NUM_NONE + 1'b1 : live_numbers[$] + 1'b1);
            CMD_REMOVE:
                for (int i = 0; i < live_numbers.size(); i++)
                    if (live_numbers[i] == num)
                    begin
                        live_numbers.delete(i);
                        break;
                    end
            default:
                ;
        endcase
    endtask

    task automatic random_request();
        int                r;
        logic [1:0]        cmd;
        logic [ID_W-1:0]   ident;
        logic [NUM_W-1:0]  num;
        logic [KIND_W-1:0] kind;
        logic              en;
        logic [ID_W-1:0]   val;
        logic [ID_W-1:0]   msk;
        r = $urandom_range(99);
        if (r < 36)
            cmd = CMD_INSERT;
        else if (r < 50)
            cmd = CMD_UPDATE;
        else if (r < 66)
            cmd = CMD_REMOVE;
        else
            cmd = CMD_FILTER;

        r = $urandom_range(99);
        if (live_numbers.size() == 0 || r < 10)
            num = NUM_W'($urandom_range(255));
        else if (cmd == CMD_REMOVE && r < 50)
            num = live_numbers[0];
        else if (r < 65)
            num = live_numbers[$];
        else
            num = live_numbers[$urandom_range(live_numbers.size() - 1)];

        kind = ($urandom_range(99) < 90)
               ? KIND_W'($urandom_range(KIND_WHITE_MASK, KIND_BLACK_EXACT))
               : KIND_W'($urandom_range(7));
        en   = ($urandom_range(99) < 80);
        val  = id_pool[$urandom_range(7)];
        if ($urandom_range(1))
            val = val ^ ID_W'($urandom_range(255));
        case ($urandom_range(4))
            0:       msk = '0;
            1:       msk = '1;
            2:       msk = {{(ID_W - 8){1'b1}}, 8'h00};
            3:       msk = {{(ID_W - 16){1'b1}}, 16'h0000};
            default: msk = ID_W'($urandom);
        endcase
        if ($urandom_range(99) < 15)
            ident = ID_W'($urandom);
        else
            ident = id_pool[$urandom_range(7)]
                    ^ ID_W'($urandom_range(1) ? $urandom_range(255) : 0);

        // noise: every field fully random
        if ($urandom_range(99) < 8)
        begin
            cmd   = 2'($urandom_range(3));
            num   = NUM_W'($urandom_range(255));
            kind  = KIND_W'($urandom_range(7));
            en    = 1'($urandom_range(1));
            val   = ID_W'($urandom);
            msk   = ID_W'($urandom);
            ident = ID_W'($urandom);
        end
        issue_request(cmd, ident, num, kind, en, val, msk);
    endtask

    // receiver side
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                out_ready <= 1'b0;
                for (int n = 0; n < LONG_STALL; n++)
                    @(posedge clk);
                hold_off_request = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        command       <= CMD_INSERT;
        frame_ident   <= '0;
        filter_number <= NUM_NONE;
        filter_kind   <= KIND_UNSET;
        enable_flag   <= 1'b0;
        match_value   <= '0;
        match_mask    <= '0;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            id_pool[i] = ID_W'($urandom);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every slot, one of each kind twice, then one too many
        for (int k = 0; k < SLOTS; k++)
            issue_request(CMD_INSERT, ID_W'($urandom), NUM_W'($urandom_range(255)),
                          KIND_W'(k % 8), 1'b1, id_pool[k % 8],
                          k[0] ? '1 : {{(ID_W - 8){1'b1}}, 8'h00});
        issue_request(CMD_INSERT, '1, NUM_MAX, KIND_WHITE_EXACT, 1'b1, '1, '1);
        issue_request(CMD_FILTER, '1, NUM_NONE, KIND_UNSET, 1'b0, '0, '0);
        issue_request(CMD_FILTER, '0, NUM_MAX, KIND_UNSET, 1'b1, '1, '1);
        issue_request(CMD_FILTER, id_pool[3], NUM_NONE, KIND_UNSET, 1'b0, '0, '0);
        issue_request(CMD_FILTER, id_pool[5] ^ 8'h3c, NUM_NONE, KIND_UNSET, 1'b0, '0, '0);
        issue_request(CMD_UPDATE, '0, live_numbers[$], KIND_WHITE_MASK, 1'b0,
                      id_pool[2], '0);
        issue_request(CMD_UPDATE, '0, NUM_NONE, KIND_BLACK_MASK, 1'b1, '1, '1);
        issue_request(CMD_REMOVE, '0, NUM_MAX, KIND_UNSET, 1'b0, '0, '0);
        issue_request(CMD_REMOVE, '0, live_numbers[0], KIND_UNSET, 1'b0, '0, '0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 26;
                    rx_idle_pct = 85;
                end
                1:
                begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 26;
                end
                default:
                begin
                    tx_idle_pct      = 0;
                    rx_idle_pct      = 0;
                    hold_off_request = 1'b1;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS; n++)
                random_request();
        end
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
